@@ src/tcsi_pkg.sv @@
package tcsi_pkg;

   // Width of the Horner accumulator; it covers every partial sum for t in [0, 1].
   localparam int HORNER_W = 40;

   localparam logic signed [HORNER_W-1:0] SAT_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [HORNER_W-1:0] SAT_MIN = 40'shFF_8000_0000;

   typedef enum logic [1:0] {
      SCALE_ZERO = 2'd0,
      SCALE_ONE  = 2'd1,
      SCALE_DIV  = 2'd2
   } scale_class_type;

   typedef struct packed {
      logic [16:0]        position;
      logic [30:0]        key_time_0;
      logic [30:0]        key_time_1;
      logic [30:0]        key_time_2;
      logic [30:0]        key_time_3;
      logic signed [31:0] point_0;
      logic signed [31:0] point_1;
      logic signed [31:0] point_2;
      logic signed [31:0] point_3;
      logic               last_component;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interpolated_value;
      logic               last_out;
   } rsp_type;

   // Classified item handed from the front end to the arithmetic back end.
   typedef struct packed {
      logic [16:0]        position;
      logic [30:0]        num;
      logic [30:0]        den_out;
      logic [30:0]        den_in;
      scale_class_type    cls_out;
      scale_class_type    cls_in;
      logic signed [31:0] p1;
      logic signed [32:0] d21;
      logic signed [32:0] e_out;
      logic signed [32:0] e_in;
      logic               last;
   } fe_type;

endpackage

@@ src/tcsi_front.sv @@
module tcsi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tcsi_pkg::req_type req_item,
   output logic             q_push,
   input  logic             q_full,
   output tcsi_pkg::fe_type fe_item
);

   logic             vld_ff;
   logic             vld_in;
   tcsi_pkg::fe_type item_ff;
   tcsi_pkg::fe_type item_in;
   logic             advance;
   logic signed [31:0] num;
   logic signed [31:0] den_out;
   logic signed [31:0] den_in;

   assign advance  = !vld_ff || !q_full;
   assign req_full = !advance;
   assign q_push   = vld_ff && !q_full;
   assign fe_item  = item_ff;
   assign vld_in   = req_push;

   assign num     = $signed({1'b0, req_item.key_time_2}) - $signed({1'b0, req_item.key_time_1});
   assign den_out = $signed({1'b0, req_item.key_time_2}) - $signed({1'b0, req_item.key_time_0});
   assign den_in  = $signed({1'b0, req_item.key_time_3}) - $signed({1'b0, req_item.key_time_1});

   always_comb begin
      item_in.position = req_item.position;
      item_in.num      = num[30:0];
      item_in.den_out  = den_out[30:0];
      item_in.den_in   = den_in[30:0];
      priority if (den_out <= 32'sd0 || num <= 32'sd0) begin
         item_in.cls_out = tcsi_pkg::SCALE_ZERO;
      end else if (num >= den_out) begin
         item_in.cls_out = tcsi_pkg::SCALE_ONE;
      end else begin
         item_in.cls_out = tcsi_pkg::SCALE_DIV;
      end
      priority if (den_in <= 32'sd0 || num <= 32'sd0) begin
         item_in.cls_in = tcsi_pkg::SCALE_ZERO;
      end else if (num >= den_in) begin
         item_in.cls_in = tcsi_pkg::SCALE_ONE;
      end else begin
         item_in.cls_in = tcsi_pkg::SCALE_DIV;
      end
      item_in.p1    = req_item.point_1;
      item_in.d21   = 33'(req_item.point_2) - 33'(req_item.point_1);
      item_in.e_out = 33'(req_item.point_2) - 33'(req_item.point_0);
      item_in.e_in  = 33'(req_item.point_3) - 33'(req_item.point_1);
      item_in.last  = req_item.last_component;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_push) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ src/tcsi_queue.sv @@
module tcsi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   output logic             q_full,
   input  tcsi_pkg::fe_type wr_item,
   input  logic             q_pop,
   output logic             q_empty,
   output tcsi_pkg::fe_type rd_item
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   tcsi_pkg::fe_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full  = (count_ff == (PTR_W + 1)'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

@@ src/tcsi_back.sv @@
module tcsi_back #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  tcsi_pkg::fe_type  q_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tcsi_pkg::rsp_type rsp_item
);

   localparam int F   = FRACTION_BITS;
   localparam int HW  = tcsi_pkg::HORNER_W;
   localparam int PW  = HW + F + 2;
   localparam int TPW = F + 35;
   localparam int NHZ = 7;
   localparam int NV  = F + NHZ + 3;
   localparam logic [31:0] ONE32 = 32'(1) << F;
   localparam logic [F:0]  SCALE_ONE_V = {1'b1, {F{1'b0}}};

   typedef struct packed {
      logic [F:0]                t;
      logic [30:0]               rem_out;
      logic [30:0]               rem_in;
      logic [30:0]               den_out;
      logic [30:0]               den_in;
      logic [F-1:0]              q_out;
      logic [F-1:0]              q_in;
      tcsi_pkg::scale_class_type cls_out;
      tcsi_pkg::scale_class_type cls_in;
      logic signed [31:0]        p1;
      logic signed [32:0]        d21;
      logic signed [32:0]        e_out;
      logic signed [32:0]        e_in;
      logic                      last;
   } div_type;

   typedef struct packed {
      logic signed [33:0] tan_out;
      logic signed [33:0] tan_in;
      logic signed [32:0] d21;
      logic signed [31:0] p1;
      logic [F:0]         t;
      logic               last;
   } tan_type;

   typedef struct packed {
      logic signed [HW-1:0] acc;
      logic signed [HW-1:0] b;
      logic signed [HW-1:0] tan_out;
      logic signed [HW-1:0] p1;
      logic [F:0]           t;
      logic                 last;
   } hz_type;

   function automatic div_type div_step(input div_type x);
      div_type     y;
      logic [31:0] sh_out;
      logic [31:0] sh_in;
      y      = x;
      sh_out = {x.rem_out, 1'b0};
      sh_in  = {x.rem_in, 1'b0};
      if (sh_out >= {1'b0, x.den_out}) begin
         y.rem_out = 31'(sh_out - {1'b0, x.den_out});
         y.q_out   = {x.q_out[F-2:0], 1'b1};
      end else begin
         y.rem_out = sh_out[30:0];
         y.q_out   = {x.q_out[F-2:0], 1'b0};
      end
      if (sh_in >= {1'b0, x.den_in}) begin
         y.rem_in = 31'(sh_in - {1'b0, x.den_in});
         y.q_in   = {x.q_in[F-2:0], 1'b1};
      end else begin
         y.rem_in = sh_in[30:0];
         y.q_in   = {x.q_in[F-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic logic [F:0] pick_scale(input tcsi_pkg::scale_class_type cls,
                                             input logic [F-1:0] quo);
      logic [F:0] s;
      unique case (cls)
         tcsi_pkg::SCALE_ZERO: s = '0;
         tcsi_pkg::SCALE_ONE:  s = SCALE_ONE_V;
         tcsi_pkg::SCALE_DIV:  s = {1'b0, quo};
         default:              s = '0;
      endcase
      return s;
   endfunction

   // Product with t, floored back to F fraction bits by the arithmetic shift.
   function automatic logic signed [HW-1:0] horner_mul(input logic signed [HW-1:0] acc,
                                                       input logic [F:0] t);
      logic signed [PW-1:0] prod;
      prod = acc * $signed({1'b0, t});
      return HW'(prod >>> F);
   endfunction

   logic [NV-1:0]        vld_ff;
   logic                 adv;
   div_type              div_ff [F+1];
   div_type              div_in;
   tan_type              tan_ff;
   tan_type              tan_in;
   hz_type               hz_ff [NHZ];
   hz_type               hz_in [NHZ];
   tcsi_pkg::rsp_type    out_ff;
   tcsi_pkg::rsp_type    out_in;
   logic [31:0]          pos32;
   logic [F:0]           scale_out;
   logic [F:0]           scale_in;
   logic signed [TPW-1:0] prod_out;
   logic signed [TPW-1:0] prod_in;
   logic signed [HW-1:0] d21_w;
   logic signed [HW-1:0] to_w;
   logic signed [HW-1:0] ti_w;

   // The whole back end moves as one; it holds only while a result waits unread.
   assign adv       = !vld_ff[NV-1] || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !vld_ff[NV-1];
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], !q_empty};
      end
   end

   assign pos32 = 32'(q_item.position);

   always_comb begin
      div_in.t       = (pos32 > ONE32) ? ONE32[F:0] : pos32[F:0];
      div_in.rem_out = q_item.num;
      div_in.rem_in  = q_item.num;
      div_in.den_out = q_item.den_out;
      div_in.den_in  = q_item.den_in;
      div_in.q_out   = '0;
      div_in.q_in    = '0;
      div_in.cls_out = q_item.cls_out;
      div_in.cls_in  = q_item.cls_in;
      div_in.p1      = q_item.p1;
      div_in.d21     = q_item.d21;
      div_in.e_out   = q_item.e_out;
      div_in.e_in    = q_item.e_in;
      div_in.last    = q_item.last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in;
      end
   end

   for (genvar k = 0; k < F; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= div_step(div_ff[k]);
         end
      end
   end

   assign scale_out = pick_scale(div_ff[F].cls_out, div_ff[F].q_out);
   assign scale_in  = pick_scale(div_ff[F].cls_in, div_ff[F].q_in);
   assign prod_out  = $signed({1'b0, scale_out}) * div_ff[F].e_out;
   assign prod_in   = $signed({1'b0, scale_in}) * div_ff[F].e_in;

   always_comb begin
      tan_in.tan_out = 34'(prod_out >>> F);
      tan_in.tan_in  = 34'(prod_in >>> F);
      tan_in.d21     = div_ff[F].d21;
      tan_in.p1      = div_ff[F].p1;
      tan_in.t       = div_ff[F].t;
      tan_in.last    = div_ff[F].last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tan_ff <= tan_in;
      end
   end

   assign d21_w = HW'(tan_ff.d21);
   assign to_w  = HW'(tan_ff.tan_out);
   assign ti_w  = HW'(tan_ff.tan_in);

   always_comb begin
      hz_in[0].acc     = to_w + ti_w - (d21_w <<< 1);
      hz_in[0].b       = (d21_w <<< 1) + d21_w - (to_w <<< 1) - ti_w;
      hz_in[0].tan_out = to_w;
      hz_in[0].p1      = HW'(tan_ff.p1);
      hz_in[0].t       = tan_ff.t;
      hz_in[0].last    = tan_ff.last;

      hz_in[1]     = hz_ff[0];
      hz_in[1].acc = horner_mul(hz_ff[0].acc, hz_ff[0].t);
      hz_in[2]     = hz_ff[1];
      hz_in[2].acc = hz_ff[1].acc + hz_ff[1].b;
      hz_in[3]     = hz_ff[2];
      hz_in[3].acc = horner_mul(hz_ff[2].acc, hz_ff[2].t);
      hz_in[4]     = hz_ff[3];
      hz_in[4].acc = hz_ff[3].acc + hz_ff[3].tan_out;
      hz_in[5]     = hz_ff[4];
      hz_in[5].acc = horner_mul(hz_ff[4].acc, hz_ff[4].t);
      hz_in[6]     = hz_ff[5];
      hz_in[6].acc = hz_ff[5].acc + hz_ff[5].p1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hz_ff <= hz_in;
      end
   end

   always_comb begin
      priority if (hz_ff[NHZ-1].acc > tcsi_pkg::SAT_MAX) begin
         out_in.interpolated_value = tcsi_pkg::SAT_MAX[31:0];
      end else if (hz_ff[NHZ-1].acc < tcsi_pkg::SAT_MIN) begin
         out_in.interpolated_value = tcsi_pkg::SAT_MIN[31:0];
      end else begin
         out_in.interpolated_value = hz_ff[NHZ-1].acc[31:0];
      end
      out_in.last_out = hz_ff[NHZ-1].last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ src/timed_cubic_spline_interpolator.sv @@
// Timed cubic spline interpolator: one component of a nonuniform Catmull-Rom
// segment per beat, in fixed point with FRACTION_BITS fraction bits.
// Request side: drive req_item and raise req_push; the beat is taken on a
// clock edge where req_full is low. Response side: while rsp_empty is low the
// oldest result sits on rsp_item, and raising rsp_pop takes it.
// A new request can be taken every cycle as long as the receiver keeps
// popping. On its way to the response side a request passes the front
// register, the two-entry queue, the back-end input register, FRACTION_BITS
// stages of the two restoring dividers (one quotient bit per stage), the
// tangent multiplier register, seven Horner stages and the result register.
// When the receiver stops popping, the back-end pipeline holds; the queue and
// the front register then fill and req_full rises, so no beat is lost.
// Reset is synchronous and clears all valid state; the block keeps no state
// between items, so results depend only on their own request.
module timed_cubic_spline_interpolator #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tcsi_pkg::req_type req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tcsi_pkg::rsp_type rsp_item
);

   logic             q_push;
   logic             q_full;
   logic             q_pop;
   logic             q_empty;
   tcsi_pkg::fe_type fe_item;
   tcsi_pkg::fe_type q_item;

   tcsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_full   (q_full),
      .fe_item  (fe_item)
   );

   tcsi_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .wr_item (fe_item),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .rd_item (q_item)
   );

   tcsi_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown right after reset");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

class spline_scoreboard;
   tcsi_pkg::rsp_type pending_values[$];
   int                mismatch_count;
   int                result_count;

   function longint floor_q(longint x);
      return x >>> 16;
   endfunction

   function longint time_scale(longint num, longint den);
      longint q;
      if (den <= 0 || num <= 0) begin
         return 0;
      end
      if (num >= den) begin
         return 64'd65536;
      end
      q = (num << 16) / den;
      return q;
   endfunction

   function tcsi_pkg::rsp_type spline_value(tcsi_pkg::req_type r);
      tcsi_pkg::rsp_type res;
      longint t, k0, k1, k2, k3, p0, p1, p2, p3;
      longint d10, d21, d32, s_out, s_in, tan_out, tan_in, acc;
      t = longint'(r.position);
      if (t > 65536) begin
         t = 65536;
      end
      k0 = longint'(r.key_time_0);
      k1 = longint'(r.key_time_1);
      k2 = longint'(r.key_time_2);
      k3 = longint'(r.key_time_3);
      p0 = longint'(r.point_0);
      p1 = longint'(r.point_1);
      p2 = longint'(r.point_2);
      p3 = longint'(r.point_3);
      d10 = p1 - p0;
      d21 = p2 - p1;
      d32 = p3 - p2;
      s_out = time_scale(k2 - k1, k2 - k0);
      s_in = time_scale(k2 - k1, k3 - k1);
      tan_out = floor_q(s_out * (d10 + d21));
      tan_in = floor_q(s_in * (d21 + d32));
      acc = -2 * d21 + tan_out + tan_in;
      acc = floor_q(acc * t);
      acc += 3 * d21 - 2 * tan_out - tan_in;
      acc = floor_q(acc * t);
      acc += tan_out;
      acc = floor_q(acc * t);
      acc += p1;
      if (acc > 64'sd2147483647) begin
         acc = 64'sd2147483647;
      end else if (acc < -64'sd2147483648) begin
         acc = -64'sd2147483648;
      end
      res.interpolated_value = acc[31:0];
      res.last_out = r.last_component;
      return res;
   endfunction

   function void note_request(tcsi_pkg::req_type r);
      pending_values.push_back(spline_value(r));
   endfunction

   function void check_result(tcsi_pkg::rsp_type got);
      tcsi_pkg::rsp_type want;
      result_count++;
      if (pending_values.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("unexpected result: value %0d last %0b",
                     got.interpolated_value, got.last_out);
         end
         return;
      end
      want = pending_values.pop_front();
      if (got.interpolated_value !== want.interpolated_value ||
          got.last_out !== want.last_out) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.interpolated_value, want.last_out,
                     got.interpolated_value, got.last_out);
         end
      end
   endfunction
endclass

module tb_top;
   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   tcsi_pkg::req_type req_item;
   logic              rsp_empty;
   logic              rsp_pop;
   tcsi_pkg::rsp_type rsp_item;

   spline_scoreboard board;
   bit      quiet_phase;
   bit      hold_receiver;
   bit      stimulus_done;
   int      stall_hits;
   int      rx_idle;

   timed_cubic_spline_interpolator dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [30:0] random_key();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(0, 40));
         1: return 31'($urandom_range(0, 100000));
         2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 40));
         default: return 31'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] random_point();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
         1: return 32'h8000_0000 + 32'($urandom_range(0, 15));
         2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   function automatic tcsi_pkg::req_type random_request();
      tcsi_pkg::req_type r;
      logic [30:0] base;
      r.position = ($urandom_range(0, 9) == 0) ? 17'($urandom()) :
                   17'($urandom_range(0, 65536));
      if ($urandom_range(0, 3) != 0) begin
         // Ordinary non-decreasing key times with modest gaps.
         base = 31'($urandom_range(0, 1000000));
         r.key_time_0 = base;
         r.key_time_1 = base + 31'($urandom_range(0, 5000));
         r.key_time_2 = r.key_time_1 + 31'($urandom_range(0, 5000));
         r.key_time_3 = r.key_time_2 + 31'($urandom_range(0, 5000));
      end else begin
         r.key_time_0 = random_key();
         r.key_time_1 = random_key();
         r.key_time_2 = random_key();
         r.key_time_3 = random_key();
      end
      r.point_0 = random_point();
      r.point_1 = random_point();
      r.point_2 = random_point();
      r.point_3 = random_point();
      r.last_component = 1'($urandom());
      return r;
   endfunction

   task automatic send_request(tcsi_pkg::req_type r);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) begin
         stall_hits++;
         @(posedge clock);
      end
      board.note_request(r);
   endtask

   function automatic tcsi_pkg::req_type make_request(logic [16:0] t, logic [30:0] k0,
                                                      logic [30:0] k1,
                                                      logic [30:0] k2, logic [30:0] k3,
                                                      logic [31:0] p0, logic [31:0] p1,
                                                      logic [31:0] p2, logic [31:0] p3,
                                                      logic last);
      tcsi_pkg::req_type r;
      r.position = t;
      r.key_time_0 = k0;
      r.key_time_1 = k1;
      r.key_time_2 = k2;
      r.key_time_3 = k3;
      r.point_0 = p0;
      r.point_1 = p1;
      r.point_2 = p2;
      r.point_3 = p3;
      r.last_component = last;
      return r;
   endfunction

   // The receiver pops with bursts of idling and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         rx_idle = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            board.check_result(rsp_item);
         end
         if (hold_receiver) begin
            rsp_pop <= 1'b0;
         end else if (rx_idle > 0) begin
            rx_idle--;
            rsp_pop <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rx_idle = $urandom_range(0, 5);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned k;
      req_push = 1'b0;
      req_item = '0;
      rsp_pop = 1'b0;
      reset = 1'b1;
      clock = 1'b0;
      quiet_phase = 1'b0;
      hold_receiver = 1'b0;
      stimulus_done = 1'b0;
      stall_hits = 0;
      rx_idle = 0;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(17'd0, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0));
      send_request(make_request(17'd65536, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1));
      send_request(make_request(17'h1FFFF, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'd5, 32'h0001_0000, 32'hFFFF_0000, 32'd7, 1'b0));
      send_request(make_request(17'd32768, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1));
      // Zero and negative time spans force both scales to zero.
      send_request(make_request(17'd30000, 31'd20, 31'd20, 31'd20, 31'd20,
                                32'h1234_5678, 32'h0001_0000, 32'h7000_0000, 32'h8000_0000,
                                1'b0));
      send_request(make_request(17'd30000, 31'h7FFF_FFFF, 31'd50, 31'd10, 31'd0,
                                32'h1234_5678, 32'h0001_0000, 32'h7000_0000, 32'h8000_0000,
                                1'b1));
      // Ratios of one and above saturate to one; the second case also has a ratio just below one.
      send_request(make_request(17'd40000, 31'd100, 31'd0, 31'd200, 31'd50,
                                32'd0, 32'h0010_0000, 32'h0020_0000, 32'h0005_0000, 1'b0));
      send_request(make_request(17'd20000, 31'd0, 31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                1'b1));
      // Overflow toward both rails.
      send_request(make_request(17'd32768, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                1'b0));
      send_request(make_request(17'd32768, 31'd0, 31'd10, 31'd20, 31'd30,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                1'b1));
      send_request(make_request(17'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1'b0));
      send_request(make_request(17'd65535, 31'd0, 31'd0, 31'd0, 31'd0,
                                32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1));

      for (k = 0; k < 700; k++) begin
         if (k == 150) begin
            hold_receiver = 1'b1;
         end
         if (k == 560) begin
            quiet_phase = 1'b1;
         end
         send_request(random_request());
      end
      req_push <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Long receiver hold-off, counted in cycles, while the sender keeps pushing.
   initial begin
      wait (hold_receiver);
      repeat (200) @(posedge clock);
      hold_receiver = 1'b0;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      $display("Covered %0d results over edge, overflow, zero-span and random spline segments;",
               board.result_count);
      $display("the input stalled on %0d cycles during the receiver hold-off.", stall_hits);
      if (board.mismatch_count == 0 && board.pending_values.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches", board.mismatch_count);
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
